/* rtl/core/rtcs_pkg.sv */
// Package: types and constants shared by the three-term recurrence checksum block
package rtcs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TERM_W  = 16;
    localparam int unsigned POS_W   = 8;

    localparam logic [BYTE_W-1:0] SEED_OFFSET = 8'd7;
    localparam logic [POS_W-1:0]  ALPHA_STEP  = 8'd17;
    localparam logic [POS_W-1:0]  BETA_STEP   = 8'd31;
    localparam logic [TERM_W-1:0] MODULUS     = 16'hFFFF;

    localparam logic [TERM_W-1:0] OLDER_INIT  = 16'd1;
    localparam logic [TERM_W-1:0] NEWER_INIT  = 16'd1;

    typedef struct packed {
        logic [TERM_W-1:0] older;
        logic [TERM_W-1:0] newer;
        logic [POS_W-1:0]  pos;
        logic              in_msg;
    } recur_state_t;

endpackage

/* rtl/core/rtcs_term_calc.sv */
// Next-term datapath: two small multiplies, wrapped difference and reduction mod 65535
module rtcs_term_calc (
    input  logic [rtcs_pkg::BYTE_W-1:0] data_byte,
    input  rtcs_pkg::recur_state_t      state,
    output logic [rtcs_pkg::TERM_W-1:0] next_term
);
    import rtcs_pkg::*;

    localparam int unsigned PROD_W = BYTE_W + 1 + TERM_W;
    localparam int unsigned SUB_W  = POS_W + TERM_W;
    localparam int unsigned DIFF_W = PROD_W + 2;
    localparam int unsigned BIAS_INT = 65535 * 512;
    localparam logic [DIFF_W-1:0] MOD_BIAS = DIFF_W'(BIAS_INT);

    logic [POS_W-1:0]    alpha;
    logic [POS_W-1:0]    beta;
    logic [BYTE_W:0]     factor;
    logic [PROD_W-1:0]   prod;
    logic [SUB_W-1:0]    sub;
    logic [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]   adj;
    logic [DIFF_W-1:0]   biased;
    logic [TERM_W:0]     folded;
    logic [TERM_W:0]     reduced;

    always_comb
    begin
        alpha   = POS_W'(state.pos * ALPHA_STEP);
        beta    = POS_W'(state.pos * BETA_STEP);
        factor  = {1'b0, data_byte} + {1'b0, alpha};
        prod    = PROD_W'(factor) * PROD_W'(state.newer);
        sub     = SUB_W'(beta) * SUB_W'(state.older);
        diff    = DIFF_W'(prod) - DIFF_W'(sub);
        // negative difference: 2^64 wrap is congruent to +1 mod 65535
        adj     = diff[DIFF_W-1] ? diff + DIFF_W'(1) : diff;
        biased  = adj + MOD_BIAS;
        folded  = (TERM_W+1)'(biased[TERM_W-1:0])
                + (TERM_W+1)'(biased[DIFF_W-2:TERM_W]);
        reduced = (folded >= (TERM_W+1)'(MODULUS))
                ? folded - (TERM_W+1)'(MODULUS) : folded;
        next_term = reduced[TERM_W-1:0];
    end

endmodule

/* rtl/core/rtcs_recur.sv */
// Recurrence state registers with seeding, term update and message end handling
module rtcs_recur (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [rtcs_pkg::BYTE_W-1:0] data_byte,
    input  logic                        last_byte,
    output logic [rtcs_pkg::TERM_W-1:0] checksum
);
    import rtcs_pkg::*;

    recur_state_t      state_reg;
    recur_state_t      state_next;
    recur_state_t      stepped;
    logic [TERM_W-1:0] term;

    rtcs_term_calc u_term_calc (
        .data_byte (data_byte),
        .state     (state_reg),
        .next_term (term)
    );

    always_comb
    begin
        if (!state_reg.in_msg)
        begin
            stepped.older  = OLDER_INIT;
            stepped.newer  = TERM_W'(data_byte) + TERM_W'(SEED_OFFSET);
            stepped.pos    = POS_W'(1);
            stepped.in_msg = 1'b1;
        end
        else
        begin
            stepped.older  = state_reg.newer;
            stepped.newer  = term;
            stepped.pos    = state_reg.pos + POS_W'(1);
            stepped.in_msg = 1'b1;
        end
        checksum = stepped.newer;
    end

    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            if (last_byte)
            begin
                state_next.older  = OLDER_INIT;
                state_next.newer  = NEWER_INIT;
                state_next.pos    = '0;
                state_next.in_msg = 1'b0;
            end
            else
            begin
                state_next = stepped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.older  <= OLDER_INIT;
            state_reg.newer  <= NEWER_INIT;
            state_reg.pos    <= '0;
            state_reg.in_msg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/three_term_recurrence_checksum_top.sv */
// Top level: stream ports, input register and checksum output register
//
// Input stream: one message byte per transaction on s_axis_tdata, s_axis_tlast
// marks the final byte of a message. Output stream: one checksum transaction per
// message on m_axis_tdata, presented after the final byte has been processed.
// Throughput: one byte per cycle unless a final byte waits on a pending checksum;
// the term update loop is combinational (two small multiplies and a mod 65535
// fold feeding the term registers). The final byte is loaded into the input
// register; its step then loads the checksum into the output register.
// Reset clears the term registers to the start-of-message state and drops both
// the input and output registers; s_axis_tready is high right after reset.
// When the receiver stalls, the checksum holds in the output register; bytes
// that end no message still flow, and a second final byte waits in the input
// register until the pending checksum is taken.
module three_term_recurrence_checksum_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] checksum
);
    import rtcs_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TERM_W-1:0] out_sum_reg;
    logic [TERM_W-1:0] sum;
    logic              step;
    logic              in_take;

    rtcs_recur u_recur (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .checksum  (sum)
    );

    always_comb
    begin
        step           = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
        s_axis_tready  = !in_valid_reg || step;
        in_take        = s_axis_tvalid && s_axis_tready;
        in_valid_next  = in_take || (in_valid_reg && !step);
        out_valid_next = (step && in_last_reg) || (out_valid_reg && !m_axis_tready);
        m_axis_tvalid  = out_valid_reg;
        m_axis_tdata   = out_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step && in_last_reg)
        begin
            out_sum_reg <= sum;
        end
    end

endmodule

/* rtl/core/rtcs_checker.sv */
// Port-level checker for the recurrence checksum top level, with its bind
module rtcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    localparam logic [15:0] NO_RESIDUE = 16'hFFFF;

    a_reset_no_output: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output transaction valid during reset");

    a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != NO_RESIDUE))
        else $error("checksum out of mod 65535 range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("checksum changed while stalled");

endmodule

bind three_term_recurrence_checksum_top rtcs_checker u_rtcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/testbench.sv */
// Testbench for the three-term recurrence checksum block: random stream traffic, scoreboard check
`timescale 1ns / 1ps

module testbench;
    import rtcs_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned BYTE_TARGET = 850;

    class checksum_tracker;
        logic [TERM_W-1:0] older_t;
        logic [TERM_W-1:0] newer_t;
        logic [POS_W-1:0]  position;
        bit                active;
        logic [TERM_W-1:0] expected_sums[$];
        int                errors;
        int                checked;
        int                bytes_seen;
        int                messages;

        function new();
            restart();
            errors     = 0;
            checked    = 0;
            bytes_seen = 0;
            messages   = 0;
        endfunction

        function void restart();
            older_t  = OLDER_INIT;
            newer_t  = NEWER_INIT;
            position = '0;
            active   = 1'b0;
        endfunction

        function logic [TERM_W-1:0] next_term(logic [BYTE_W-1:0] b);
            longint unsigned alpha;
            longint unsigned beta;
            longint unsigned prod;
            longint unsigned sub;
            longint unsigned modv;
            longint unsigned k;
            modv  = longint'(MODULUS);
            alpha = (longint'(position) * longint'(ALPHA_STEP)) % 256;
            beta  = (longint'(position) * longint'(BETA_STEP)) % 256;
            prod  = (longint'(b) + alpha) * longint'(newer_t);
            sub   = beta * longint'(older_t);
            if (prod >= sub)
                return TERM_W'((prod - sub) % modv);
            // 64-bit wrap: 2^64 == 1 mod 65535
            k = (sub - prod - 1) % modv;
            return TERM_W'((modv - k) % modv);
        endfunction

        function void absorb_byte(logic [BYTE_W-1:0] b, logic last);
            logic [TERM_W-1:0] t;
            bytes_seen++;
            if (!active)
            begin
                older_t  = OLDER_INIT;
                newer_t  = TERM_W'(b) + TERM_W'(SEED_OFFSET);
                position = POS_W'(1);
                active   = 1'b1;
            end
            else
            begin
                t        = next_term(b);
                older_t  = newer_t;
                newer_t  = t;
                position = position + POS_W'(1);
            end
            if (last)
            begin
                expected_sums.push_back(newer_t);
                messages++;
                restart();
            end
        endfunction

        function void check_checksum(logic [TERM_W-1:0] actual);
            logic [TERM_W-1:0] want;
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected checksum, expected none, actual %0d", $time, actual);
                errors++;
                return;
            end
            want = expected_sums.pop_front();
            checked++;
            if (actual !== want)
            begin
                $display("%0t: checksum mismatch, expected %0d, actual %0d", $time, want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [15:0] checksum

    checksum_tracker tracker = new();

    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_count = 0;
    int unsigned rx_mode = 0;

    three_term_recurrence_checksum_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver: checks results, stalls in changing modes
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_checksum(m_axis_tdata);
        rx_count <= rx_count + 1;
        if (rx_count % 64 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_count % 5 == 0);
            default: m_axis_tready <= (rx_count % 32 >= 30);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d checksums outstanding", $time, tracker.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        tracker.absorb_byte(b, last);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80) : $urandom_range(0, 12);
        end
    endtask

    task automatic send_message(input int len, input bit fixed, input logic [7:0] value);
        for (int i = 0; i < len; i++)
            send_byte(fixed ? value : 8'($urandom), i == len - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int len;
        int long_msgs;
        long_msgs = 0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte messages at the extremes, then one random byte
        send_message(1, 1, 8'h00);
        send_message(1, 1, 8'hFF);
        send_message(1, 0, 8'h00);
        // short messages of extreme bytes, then one of random bytes
        send_message(2, 1, 8'hFF);
        send_message(3, 1, 8'h00);
        send_message(4, 1, 8'hFF);
        send_message(5, 1, 8'h00);
        send_message(6, 0, 8'h00);
        drain();

        // position wrap: message longer than 256 bytes
        send_message($urandom_range(257, 300), 0, 8'h00);
        while (tracker.bytes_seen < BYTE_TARGET)
        begin
            if (long_msgs < 1 && tracker.bytes_seen + 300 < BYTE_TARGET
                && $urandom_range(0, 40) == 0)
            begin
                len = $urandom_range(256, 280);
                long_msgs++;
            end
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 3);
            else
                len = $urandom_range(1, 20);
            send_message(len, 0, 8'h00);
            if ($urandom_range(0, 24) == 0)
                drain();
        end
        drain();

        $display("Sent %0d bytes in %0d messages; checked %0d checksums, incl. position wrap",
                 tracker.bytes_seen, tracker.messages, tracker.checked);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* three_term_recurrence_checksum_top.f */
rtl/core/rtcs_pkg.sv
rtl/core/rtcs_term_calc.sv
rtl/core/rtcs_recur.sv
rtl/core/three_term_recurrence_checksum_top.sv
rtl/core/rtcs_checker.sv
verif/testbench.sv
